[hdl/ssi_pkg.sv]
package ssi_pkg;

    localparam int CAPACITY    = 32;
    localparam int MAX_RESULTS = 32;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_LOAD_A  = 2'd0;
    localparam kind_t KIND_LOAD_B  = 2'd1;
    localparam kind_t KIND_COMPUTE = 2'd2;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

endpackage

[hdl/ssi_ram.sv]
module ssi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/ssi_cmp.sv]
module ssi_cmp (
    input  logic signed [ssi_pkg::DATA_W-1:0] x,
    input  logic signed [ssi_pkg::DATA_W-1:0] y,
    output ssi_pkg::cmp_res_t                 res
);

    import ssi_pkg::*;

    // signed order throughout
    assign res.gt = (x > y);
    assign res.eq = (x == y);

endmodule

[hdl/sorted_set_intersection.sv]
// Load request: busy while the value is inserted (not busy if the list is full and the value
//   is dropped); insertion into place, one shift per cycle through the list RAM and shared
//   comparator. Compute request: one merge step per cycle; results on strobe, the last one
//   in the same cycle as busy falls. Single-cycle strobes; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties both lists and clears the overflow flag.
module sorted_set_intersection (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ssi_pkg::kind_t                    kind,
    input  logic signed [ssi_pkg::DATA_W-1:0] value,
    output logic                              strobe,
    output logic signed [ssi_pkg::DATA_W-1:0] common_value,
    output logic                              last,
    output logic                              empty_res,
    output logic                              overflow
);

    import ssi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_LAST,
        S_MRG_CMP,
        S_MRG_END
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         count_a_reg, count_a_next;
    logic [CNT_W-1:0]         count_b_reg, count_b_next;
    logic                     ovf_reg, ovf_next;
    logic                     sel_b_reg, sel_b_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [RES_W-1:0]         n_reg, n_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic signed [DATA_W-1:0] pend_reg, pend_next;

    logic                     strobe_reg, strobe_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     last_reg, last_next;
    logic                     empty_reg, empty_next;
    logic                     ovf_out_reg, ovf_out_next;

    logic                     we_a, we_b;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]        raddr_a, raddr_b;
    logic [DATA_W-1:0]        rdata_a, rdata_b;
    logic signed [DATA_W-1:0] rd_sel;

    logic signed [DATA_W-1:0] cmp_x, cmp_y;
    cmp_res_t                 cmp;

    logic [CNT_W-1:0]         cnt_a_m1, cnt_b_m1, j_m1, j_m2;
    logic [CNT_W-1:0]         mi, mj;
    logic [RES_W-1:0]         mn;
    logic                     accept;

    ssi_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    ssi_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    ssi_cmp u_cmp (
        .x   (cmp_x),
        .y   (cmp_y),
        .res (cmp)
    );

    assign accept   = start && (state_reg == S_IDLE);
    assign cnt_a_m1 = count_a_reg - 1'b1;
    assign cnt_b_m1 = count_b_reg - 1'b1;
    assign j_m1     = j_reg - 1'b1;
    assign j_m2     = j_reg - 2'd2;
    assign rd_sel   = sel_b_reg ? $signed(rdata_b) : $signed(rdata_a);

    // comparator shared between insertion and merge
    always_comb
    begin
        if (state_reg == S_INS_CMP)
        begin
            cmp_x = rd_sel;
            cmp_y = key_reg;
        end
        else
        begin
            cmp_x = $signed(rdata_a);
            cmp_y = $signed(rdata_b);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        ovf_next        = ovf_reg;
        sel_b_next      = sel_b_reg;
        key_next        = key_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        strobe_next     = 1'b0;
        value_next      = value_reg;
        last_next       = last_reg;
        empty_next      = empty_reg;
        ovf_out_next    = ovf_out_reg;
        we_a            = 1'b0;
        we_b            = 1'b0;
        waddr           = j_reg[ADDR_W-1:0];
        wdata           = key_reg;
        raddr_a         = '0;
        raddr_b         = '0;
        mi              = i_reg;
        mj              = j_reg;
        mn              = n_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                raddr_a = (kind == KIND_LOAD_A) ? cnt_a_m1[ADDR_W-1:0] : '0;
                raddr_b = (kind == KIND_LOAD_B) ? cnt_b_m1[ADDR_W-1:0] : '0;
                if (accept)
                begin
                    unique case (kind)
                        KIND_LOAD_A, KIND_LOAD_B:
                        begin
                            sel_b_next = (kind == KIND_LOAD_B);
                            key_next   = value;
                            j_next     = (kind == KIND_LOAD_B) ? count_b_reg : count_a_reg;
                            if (((kind == KIND_LOAD_A) && (count_a_reg == CNT_W'(CAPACITY))) ||
                                ((kind == KIND_LOAD_B) && (count_b_reg == CNT_W'(CAPACITY))))
                            begin
                                ovf_next = 1'b1;
                            end
                            else if (((kind == KIND_LOAD_A) && (count_a_reg == '0)) ||
                                     ((kind == KIND_LOAD_B) && (count_b_reg == '0)))
                            begin
                                state_next = S_INS_LAST;
                            end
                            else
                            begin
                                state_next = S_INS_CMP;
                            end
                        end
                        KIND_COMPUTE:
                        begin
                            i_next          = '0;
                            j_next          = '0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                            if ((count_a_reg == '0) || (count_b_reg == '0))
                            begin
                                state_next = S_MRG_END;
                            end
                            else
                            begin
                                state_next = S_MRG_CMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_INS_CMP:
            begin
                raddr_a = j_m2[ADDR_W-1:0];
                raddr_b = j_m2[ADDR_W-1:0];
                we_a    = !sel_b_reg;
                we_b    = sel_b_reg;
                if (cmp.gt)
                begin
                    // shift the larger entry up one place
                    wdata  = rd_sel;
                    j_next = j_m1;
                    if (j_reg == CNT_W'(1))
                    begin
                        state_next = S_INS_LAST;
                    end
                end
                else
                begin
                    if (sel_b_reg)
                    begin
                        count_b_next = count_b_reg + 1'b1;
                    end
                    else
                    begin
                        count_a_next = count_a_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_INS_LAST:
            begin
                we_a  = !sel_b_reg;
                we_b  = sel_b_reg;
                waddr = '0;
                if (sel_b_reg)
                begin
                    count_b_next = count_b_reg + 1'b1;
                end
                else
                begin
                    count_a_next = count_a_reg + 1'b1;
                end
                state_next = S_IDLE;
            end

            S_MRG_CMP:
            begin
                if (cmp.eq)
                begin
                    // the held result is the latest match, so a repeat equals it
                    if (!pend_valid_reg || (pend_reg != $signed(rdata_a)))
                    begin
                        if (pend_valid_reg)
                        begin
                            strobe_next  = 1'b1;
                            value_next   = pend_reg;
                            last_next    = 1'b0;
                            empty_next   = 1'b0;
                            ovf_out_next = ovf_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = $signed(rdata_a);
                        mn              = n_reg + 1'b1;
                    end
                    mi = i_reg + 1'b1;
                    mj = j_reg + 1'b1;
                end
                else if (cmp.gt)
                begin
                    mj = j_reg + 1'b1;
                end
                else
                begin
                    mi = i_reg + 1'b1;
                end
                i_next  = mi;
                j_next  = mj;
                n_next  = mn;
                raddr_a = mi[ADDR_W-1:0];
                raddr_b = mj[ADDR_W-1:0];
                if ((mi >= count_a_reg) || (mj >= count_b_reg) ||
                    (mn >= RES_W'(MAX_RESULTS)))
                begin
                    state_next = S_MRG_END;
                end
            end

            S_MRG_END:
            begin
                strobe_next  = 1'b1;
                last_next    = 1'b1;
                ovf_out_next = ovf_reg;
                if (pend_valid_reg)
                begin
                    value_next = pend_reg;
                    empty_next = 1'b0;
                end
                else
                begin
                    value_next = '0;
                    empty_next = 1'b1;
                end
                count_a_next = '0;
                count_b_next = '0;
                ovf_next     = 1'b0;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            ovf_reg        <= 1'b0;
            sel_b_reg      <= 1'b0;
            key_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            strobe_reg     <= 1'b0;
            value_reg      <= '0;
            last_reg       <= 1'b0;
            empty_reg      <= 1'b0;
            ovf_out_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            ovf_reg        <= ovf_next;
            sel_b_reg      <= sel_b_next;
            key_reg        <= key_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            strobe_reg     <= strobe_next;
            value_reg      <= value_next;
            last_reg       <= last_next;
            empty_reg      <= empty_next;
            ovf_out_reg    <= ovf_out_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = strobe_reg;
    assign common_value = value_reg;
    assign last         = last_reg;
    assign empty_res    = empty_reg;
    assign overflow     = ovf_out_reg;

endmodule

[tb/sorted_set_intersection_tb.sv]
module sorted_set_intersection_tb;

    import ssi_pkg::*;

    localparam kind_t KIND_UNUSED = 2'd3;
    localparam int    RANDOM_REQS = 100;
    localparam int    TAIL_CYCLES = 2 * CAPACITY + 16;
    localparam int    CYCLE_LIMIT = 200000;

    typedef struct packed {
        kind_t                    kind;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] common_value;
        logic                     last;
        logic                     empty_res;
        logic                     overflow;
    } common_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
    logic                     strobe;
    logic signed [DATA_W-1:0] common_value;
    logic                     last;
    logic                     empty_res;
    logic                     overflow;

    sorted_set_intersection DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .value        (value),
        .strobe       (strobe),
        .common_value (common_value),
        .last         (last),
        .empty_res    (empty_res),
        .overflow     (overflow)
    );

    // requests waiting to go out, and results still owed by the block
    req_t    pending_q[$];
    common_t common_q[$];

    // shadow of the block's two lists
    logic signed [DATA_W-1:0] held[2][CAPACITY];
    int                       held_cnt[2];
    bit                       dropped;

    int errors;
    int cycles;

    // driver state
    req_t cur_req;
    bit   holding;
    bit   req_taken;
    int   idle_left;
    bit   no_idle;

    // monitor state
    common_t want;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic note_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    task automatic sort_held(input int l);
        int                       i;
        int                       j;
        logic signed [DATA_W-1:0] key;
        for (i = 1; i < held_cnt[l]; i++)
        begin
            key = held[l][i];
            j = i;
            while (j > 0 && held[l][j-1] > key)
            begin
                held[l][j] = held[l][j-1];
                j--;
            end
            held[l][j] = key;
        end
    endtask

    // two-pointer merge over the sorted lists; each distinct common value once
    task automatic intersect_lists();
        logic signed [DATA_W-1:0] found[MAX_RESULTS];
        logic signed [DATA_W-1:0] prev;
        bit                       have_prev;
        int                       i;
        int                       j;
        int                       n;
        int                       k;
        common_t                  r;
        sort_held(0);
        sort_held(1);
        i = 0;
        j = 0;
        n = 0;
        have_prev = 1'b0;
        prev = '0;
        while (i < held_cnt[0] && j < held_cnt[1] && n < MAX_RESULTS)
        begin
            if (held[0][i] == held[1][j])
            begin
                if (!have_prev || prev != held[0][i])
                begin
                    found[n] = held[0][i];
                    n++;
                    prev = held[0][i];
                    have_prev = 1'b1;
                end
                i++;
                j++;
            end
            else if (held[0][i] < held[1][j])
                i++;
            else
                j++;
        end
        if (n == 0)
        begin
            r.common_value = '0;
            r.last = 1'b1;
            r.empty_res = 1'b1;
            r.overflow = dropped;
            common_q.insert(common_q.size(), r);
        end
        else
        begin
            for (k = 0; k < n; k++)
            begin
                r.common_value = found[k];
                r.last = (k == n - 1);
                r.empty_res = 1'b0;
                r.overflow = dropped;
                common_q.insert(common_q.size(), r);
            end
        end
        held_cnt[0] = 0;
        held_cnt[1] = 0;
        dropped = 1'b0;
    endtask

    task automatic apply_request(input kind_t k, input logic signed [DATA_W-1:0] v);
        int l;
        case (k)
            KIND_LOAD_A, KIND_LOAD_B:
            begin
                l = (k == KIND_LOAD_B) ? 1 : 0;
                if (held_cnt[l] < CAPACITY)
                begin
                    held[l][held_cnt[l]] = v;
                    held_cnt[l]++;
                end
                else
                    dropped = 1'b1;
            end
            KIND_COMPUTE:
                intersect_lists();
            default:
                ;
        endcase
    endtask

    task automatic queue_req(input kind_t k, input logic signed [DATA_W-1:0] v);
        req_t q;
        q.kind = k;
        q.value = v;
        pending_q.insert(pending_q.size(), q);
    endtask

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holding && req_taken)
                holding = 1'b0;
            if (!holding)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (pending_q.size() > 0)
                begin
                    cur_req = pending_q.pop_front();
                    holding = 1'b1;
                    idle_left = no_idle ? 0 : $urandom_range(0, 3);
                    if ($urandom_range(0, 15) == 0)
                        no_idle = !no_idle;
                end
            end
            start <= holding;
            if (holding)
            begin
                kind <= cur_req.kind;
                value <= cur_req.value;
            end
        end
    end

    // monitor and predictor: sampled on the rising edge
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sorted_set_intersection_tb: FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (strobe)
            begin
                if (common_q.size() == 0)
                    note_mismatch($sformatf("unexpected result %0d", common_value));
                else
                begin
                    want = common_q.pop_front();
                    if (common_value !== want.common_value)
                        note_mismatch($sformatf("common_value %0d, want %0d",
                                                common_value, want.common_value));
                    if (last !== want.last)
                        note_mismatch($sformatf("last %b, want %b", last, want.last));
                    if (empty_res !== want.empty_res)
                        note_mismatch($sformatf("empty_res %b, want %b",
                                                empty_res, want.empty_res));
                    if (overflow !== want.overflow)
                        note_mismatch($sformatf("overflow %b, want %b",
                                                overflow, want.overflow));
                end
            end
            req_taken = start && !busy;
            if (req_taken)
                apply_request(kind, value);
        end
    end

    initial
    begin
        logic signed [DATA_W-1:0] hot[4];
        logic signed [DATA_W-1:0] spread[CAPACITY];
        logic signed [DATA_W-1:0] t;
        int                       made;
        int                       jobs;
        int                       na;
        int                       nb;
        int                       p;
        int                       q;

        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_LOAD_A;
        value = '0;
        errors = 0;
        cycles = 0;
        holding = 1'b0;
        req_taken = 1'b0;
        idle_left = 0;
        no_idle = 1'b0;
        held_cnt[0] = 0;
        held_cnt[1] = 0;
        dropped = 1'b0;

        // directed: both lists empty, ignored code, extremes, duplicates
        queue_req(KIND_COMPUTE, '0);
        queue_req(KIND_UNUSED, 32'hFFFF_FFFF);
        queue_req(KIND_LOAD_A, 32'sh7FFF_FFFF);
        queue_req(KIND_LOAD_A, 32'sh8000_0000);
        queue_req(KIND_LOAD_A, -32'sd1);
        queue_req(KIND_LOAD_A, 32'sd0);
        queue_req(KIND_LOAD_A, 32'sh7FFF_FFFF);
        queue_req(KIND_LOAD_B, 32'sd0);
        queue_req(KIND_LOAD_B, 32'sh7FFF_FFFF);
        queue_req(KIND_LOAD_B, 32'sh8000_0000);
        queue_req(KIND_LOAD_B, 32'sh7FFF_FFFF);
        queue_req(KIND_LOAD_B, 32'sd5);
        queue_req(KIND_UNUSED, 32'h5555_5555);
        queue_req(KIND_COMPUTE, 32'hAAAA_AAAA);
        // one list empty
        queue_req(KIND_LOAD_A, 32'sd123);
        queue_req(KIND_COMPUTE, '0);
        // duplicates in one list only
        queue_req(KIND_LOAD_B, -32'sd7);
        queue_req(KIND_LOAD_B, -32'sd7);
        queue_req(KIND_LOAD_A, -32'sd7);
        queue_req(KIND_COMPUTE, '0);

        made = 0;
        jobs = 0;
        while (made < RANDOM_REQS || jobs <= 2)
        begin
            if (jobs == 2)
            begin
                // both lists full with the same distinct values, then overfilled
                for (p = 0; p < CAPACITY; p++)
                    spread[p] = ($urandom() & 32'hFFFF_FFE0) | p;
                for (p = CAPACITY - 1; p > 0; p--)
                begin
                    q = $urandom_range(0, p);
                    t = spread[p];
                    spread[p] = spread[q];
                    spread[q] = t;
                end
                for (p = 0; p < CAPACITY; p++)
                    queue_req(KIND_LOAD_A, spread[p]);
                for (p = CAPACITY - 1; p >= 0; p--)
                    queue_req(KIND_LOAD_B, spread[p]);
                queue_req(KIND_LOAD_A, $urandom());
                queue_req(KIND_LOAD_B, $urandom());
                queue_req(KIND_LOAD_B, spread[0]);
                queue_req(KIND_COMPUTE, $urandom());
                made += 2 * CAPACITY + 4;
            end
            else
            begin
                hot[0] = $urandom();
                hot[1] = $signed($urandom_range(0, 6)) - 3;
                hot[2] = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                hot[3] = $urandom();
                if ($urandom_range(0, 7) == 0)
                begin
                    na = $urandom_range(20, CAPACITY + 1);
                    nb = $urandom_range(20, CAPACITY + 1);
                end
                else
                begin
                    na = $urandom_range(0, 7);
                    nb = $urandom_range(0, 7);
                end
                while (na + nb > 0)
                begin
                    if ($urandom_range(0, 3) != 0)
                        t = hot[$urandom_range(0, 3)];
                    else
                        t = $urandom();
                    if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 0))
                    begin
                        queue_req(KIND_LOAD_A, t);
                        na--;
                    end
                    else
                    begin
                        queue_req(KIND_LOAD_B, t);
                        nb--;
                    end
                    made++;
                    if ($urandom_range(0, 19) == 0)
                        queue_req(KIND_UNUSED, $urandom());
                end
                queue_req(KIND_COMPUTE, $urandom());
                made++;
            end
            jobs++;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || holding || common_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("sorted_set_intersection_tb: PASS");
        else
            $display("sorted_set_intersection_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/ssi_pkg.sv
hdl/ssi_ram.sv
hdl/ssi_cmp.sv
hdl/sorted_set_intersection.sv
tb/sorted_set_intersection_tb.sv
